// ===== rtl/ttp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ttp_pkg;

   // sizes
   localparam int MAX_EDGES  = 64;
   localparam int NODE_SLOTS = MAX_EDGES + 2;
   localparam int NODE_W     = 7;
   localparam int EDGE_W     = $clog2(MAX_EDGES);
   localparam int CNT_W      = $clog2(MAX_EDGES + 1);

   // request op codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_DROP   = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   // controller steps, shared with the datapath as the command
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_IDLE  = 5'd0;
   localparam logic [STEP_W-1:0] STEP_LOAD1 = 5'd1;
   localparam logic [STEP_W-1:0] STEP_LOAD2 = 5'd2;
   localparam logic [STEP_W-1:0] STEP_DROP0 = 5'd3;
   localparam logic [STEP_W-1:0] STEP_DROP1 = 5'd4;
   localparam logic [STEP_W-1:0] STEP_DROP2 = 5'd5;
   localparam logic [STEP_W-1:0] STEP_SCAN  = 5'd6;
   localparam logic [STEP_W-1:0] STEP_SPL1  = 5'd7;
   localparam logic [STEP_W-1:0] STEP_SPL2  = 5'd8;
   localparam logic [STEP_W-1:0] STEP_SPL3  = 5'd9;
   localparam logic [STEP_W-1:0] STEP_SPL4  = 5'd10;
   localparam logic [STEP_W-1:0] STEP_NUM   = 5'd11;
   localparam logic [STEP_W-1:0] STEP_ECHK  = 5'd12;
   localparam logic [STEP_W-1:0] STEP_ERD1  = 5'd13;
   localparam logic [STEP_W-1:0] STEP_ERD2  = 5'd14;
   localparam logic [STEP_W-1:0] STEP_EEND  = 5'd15;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              accept;
   } ttp_cmd_type;

   typedef struct packed {
      logic load_ok;
      logic tip_ok;
      logic np_zero;
      logic cnt_zero;
      logic cnt_two;
      logic scan_hit;
      logic scan_end;
      logic num_end;
      logic e_end;
      logic e_dropped;
      logic out_free;
   } ttp_status_type;

endpackage

`default_nettype wire

// ===== rtl/ttp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read, old data on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ttp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic [1:0]              req_op,
   output logic                         req_ready,
   input  wire ttp_pkg::ttp_status_type status,
   output ttp_pkg::ttp_cmd_type         cmd
);
   import ttp_pkg::*;

   logic [STEP_W-1:0] state_ff;
   logic [STEP_W-1:0] state_in;

   assign req_ready  = (state_ff == STEP_IDLE);
   assign cmd.step   = state_ff;
   assign cmd.accept = req_valid && (state_ff == STEP_IDLE);

   // next step
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STEP_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_LOAD && status.load_ok) begin
                  state_in = STEP_LOAD1;
               end else if (req_op == OP_DROP && status.tip_ok) begin
                  state_in = STEP_DROP0;
               end else if (req_op == OP_FINISH) begin
                  state_in = STEP_NUM;
               end
            end
         end
         STEP_LOAD1: state_in = STEP_LOAD2;
         STEP_LOAD2: state_in = STEP_IDLE;
         STEP_DROP0: state_in = STEP_DROP1;
         STEP_DROP1: state_in = status.np_zero ? STEP_IDLE : STEP_DROP2;
         STEP_DROP2: begin
            state_in = (status.cnt_zero || !status.cnt_two) ? STEP_IDLE : STEP_SCAN;
         end
         STEP_SCAN: begin
            if (status.scan_hit) begin
               state_in = STEP_SPL1;
            end else if (status.scan_end) begin
               state_in = STEP_IDLE;
            end
         end
         STEP_SPL1: state_in = STEP_SPL2;
         STEP_SPL2: state_in = STEP_SPL3;
         STEP_SPL3: state_in = STEP_SPL4;
         STEP_SPL4: state_in = STEP_IDLE;
         STEP_NUM:  state_in = status.num_end ? STEP_ECHK : STEP_NUM;
         STEP_ECHK: begin
            if (status.e_end) begin
               state_in = STEP_EEND;
            end else if (!status.e_dropped) begin
               state_in = STEP_ERD1;
            end
         end
         STEP_ERD1: state_in = STEP_ERD2;
         STEP_ERD2: state_in = status.out_free ? STEP_ECHK : STEP_ERD2;
         STEP_EEND: state_in = status.out_free ? STEP_IDLE : STEP_EEND;
         default:   state_in = STEP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STEP_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ttp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttp_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire ttp_pkg::ttp_cmd_type               cmd,
   output ttp_pkg::ttp_status_type                 status,
   input  wire logic [ttp_pkg::NODE_W-1:0]         req_parent_node,
   input  wire logic [ttp_pkg::NODE_W-1:0]         req_child_node,
   input  wire logic [ttp_pkg::NODE_W-1:0]         req_tip_node,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [ttp_pkg::NODE_W-1:0]         rsp_new_parent,
   output logic      [ttp_pkg::NODE_W-1:0]         rsp_new_child_node,
   output logic                                    rsp_is_empty,
   output logic                                    rsp_last
);
   import ttp_pkg::*;

   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODE_SLOTS - 1);
   localparam logic [CNT_W-1:0]  EDGE_FULL = CNT_W'(MAX_EDGES);

   // captured request
   logic [NODE_W-1:0] p_ff, c_ff, t_ff;
   // drop working registers
   logic [NODE_W-1:0] np_ff, k_ff, gp_ff, scan_ff, chk_k_ff;
   logic              chk_valid_ff;
   // finish working registers
   logic [NODE_W-1:0] i_ff, drop_cnt_ff;
   logic [CNT_W-1:0]  fe_ff, e_cnt_ff;
   logic [NODE_W-1:0] hold_par_ff, hold_chd_ff;
   logic              hold_valid_ff;
   // valid bits and drop marks
   logic [NODE_SLOTS-1:0] pv_ff, pv_in, cv_ff, cv_in, uv_ff, uv_in;
   logic [NODE_SLOTS-1:0] dmark_ff, dmark_in;
   logic [MAX_EDGES-1:0]  edrop_ff, edrop_in;
   logic                  pq_ff, cq_ff, uq_ff;
   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] rsp_par_ff, rsp_par_in, rsp_chd_ff, rsp_chd_in;
   logic              rsp_empty_ff, rsp_empty_in, rsp_last_ff, rsp_last_in;

   // ram ports
   logic              p_we, c_we, u_we, ep_we, ec_we, rn_we;
   logic [NODE_W-1:0] p_wa, p_ra, c_wa, c_ra, u_wa, u_ra, rn_wa;
   logic [NODE_W-1:0] p_wd, c_wd, rn_wd;
   logic [EDGE_W-1:0] u_wd, ep_wa, ec_wa;
   logic [NODE_W-1:0] ep_wd, ec_wd;
   logic [NODE_W-1:0] p_raw, c_raw, ep_rd, ec_rd, rn_par, rn_chd;
   logic [EDGE_W-1:0] u_raw;
   logic [NODE_W-1:0] p_rd, c_rd;
   logic [EDGE_W-1:0] u_rd;
   logic              out_free;

   ttp_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_par_ram (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_raw));
   ttp_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_cnt_ram (
      .clock, .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd), .rd_addr(c_ra), .rd_data(c_raw));
   ttp_ram #(.WIDTH(EDGE_W), .DEPTH(NODE_SLOTS)) u_up_ram (
      .clock, .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd), .rd_addr(u_ra), .rd_data(u_raw));
   ttp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_epar_ram (
      .clock, .wr_en(ep_we), .wr_addr(ep_wa), .wr_data(ep_wd),
      .rd_addr(fe_ff[EDGE_W-1:0]), .rd_data(ep_rd));
   ttp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_echd_ram (
      .clock, .wr_en(ec_we), .wr_addr(ec_wa), .wr_data(ec_wd),
      .rd_addr(fe_ff[EDGE_W-1:0]), .rd_data(ec_rd));
   ttp_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_rnp_ram (
      .clock, .wr_en(rn_we), .wr_addr(rn_wa), .wr_data(rn_wd), .rd_addr(ep_rd),
      .rd_data(rn_par));
   ttp_ram #(.WIDTH(NODE_W), .DEPTH(NODE_SLOTS)) u_rnc_ram (
      .clock, .wr_en(rn_we), .wr_addr(rn_wa), .wr_data(rn_wd), .rd_addr(ec_rd),
      .rd_data(rn_chd));

   // unwritten node entries read as zero
   assign p_rd = pq_ff ? p_raw : '0;
   assign c_rd = cq_ff ? c_raw : '0;
   assign u_rd = uq_ff ? u_raw : '0;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // status toward the controller
   assign status.load_ok   = (e_cnt_ff < EDGE_FULL) &&
                             (req_parent_node < NODE_W'(NODE_SLOTS)) &&
                             (req_child_node < NODE_W'(NODE_SLOTS));
   assign status.tip_ok    = req_tip_node < NODE_W'(NODE_SLOTS);
   assign status.np_zero   = (p_rd == '0);
   assign status.cnt_zero  = (c_rd == '0);
   assign status.cnt_two   = (c_rd == NODE_W'(2));
   assign status.scan_hit  = chk_valid_ff && (p_rd == np_ff);
   assign status.scan_end  = chk_valid_ff && (chk_k_ff == LAST_NODE);
   assign status.num_end   = (i_ff == LAST_NODE);
   assign status.e_end     = (fe_ff == e_cnt_ff);
   assign status.e_dropped = edrop_ff[fe_ff[EDGE_W-1:0]];
   assign status.out_free  = out_free;

   // memory controls and mark updates per step
   always_comb begin
      p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
      c_we = 1'b0; c_wa = '0; c_wd = '0; c_ra = '0;
      u_we = 1'b0; u_wa = '0; u_wd = '0; u_ra = '0;
      ep_we = 1'b0; ep_wa = '0; ep_wd = '0;
      ec_we = 1'b0; ec_wa = '0; ec_wd = '0;
      rn_we = 1'b0; rn_wa = '0; rn_wd = '0;
      pv_in = pv_ff; cv_in = cv_ff; uv_in = uv_ff;
      dmark_in = dmark_ff; edrop_in = edrop_ff;
      unique case (cmd.step)
         STEP_LOAD1: begin
            ep_we = 1'b1; ep_wa = e_cnt_ff[EDGE_W-1:0]; ep_wd = p_ff;
            ec_we = 1'b1; ec_wa = e_cnt_ff[EDGE_W-1:0]; ec_wd = c_ff;
            edrop_in[e_cnt_ff[EDGE_W-1:0]] = 1'b0;
            p_we = 1'b1; p_wa = c_ff; p_wd = p_ff; pv_in[c_ff] = 1'b1;
            u_we = 1'b1; u_wa = c_ff; u_wd = e_cnt_ff[EDGE_W-1:0]; uv_in[c_ff] = 1'b1;
            c_ra = p_ff;
         end
         STEP_LOAD2: begin
            c_we = 1'b1; c_wa = p_ff; c_wd = c_rd + NODE_W'(1); cv_in[p_ff] = 1'b1;
         end
         STEP_DROP0: begin
            dmark_in[t_ff] = 1'b1;
            p_ra = t_ff;
            u_ra = t_ff;
         end
         STEP_DROP1: begin
            c_ra = p_rd;
            if (p_rd != '0) begin
               edrop_in[u_rd] = 1'b1;
               p_we = 1'b1; p_wa = t_ff; p_wd = '0; pv_in[t_ff] = 1'b1;
            end
         end
         STEP_DROP2: begin
            if (c_rd != '0) begin
               c_we = 1'b1; c_wa = np_ff; c_wd = c_rd - NODE_W'(1); cv_in[np_ff] = 1'b1;
            end
         end
         STEP_SCAN: begin
            p_ra = scan_ff;
         end
         STEP_SPL1: begin
            u_ra = k_ff;
            p_ra = np_ff;
         end
         STEP_SPL2: begin
            edrop_in[u_rd] = 1'b1;
            dmark_in[np_ff] = 1'b1;
            u_ra = np_ff;
         end
         STEP_SPL3: begin
            if (gp_ff != '0) begin
               u_we = 1'b1; u_wa = k_ff; u_wd = u_rd; uv_in[k_ff] = 1'b1;
               ec_we = 1'b1; ec_wa = u_rd; ec_wd = k_ff;
            end
            p_we = 1'b1; p_wa = k_ff; p_wd = gp_ff; pv_in[k_ff] = 1'b1;
         end
         STEP_SPL4: begin
            p_we = 1'b1; p_wa = np_ff; p_wd = '0; pv_in[np_ff] = 1'b1;
         end
         STEP_NUM: begin
            rn_we = 1'b1; rn_wa = i_ff;
            rn_wd = ((i_ff == '0) || dmark_ff[i_ff]) ? '0 : i_ff - drop_cnt_ff;
         end
         STEP_EEND: begin
            if (out_free) begin
               pv_in = '0; cv_in = '0; uv_in = '0;
               dmark_in = '0; edrop_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_par_in   = rsp_par_ff;
      rsp_chd_in   = rsp_chd_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.step == STEP_ERD2 && out_free && hold_valid_ff) begin
         rsp_valid_in = 1'b1;
         rsp_par_in   = hold_par_ff;
         rsp_chd_in   = hold_chd_ff;
         rsp_empty_in = 1'b0;
         rsp_last_in  = 1'b0;
      end else if (cmd.step == STEP_EEND && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_par_in   = hold_valid_ff ? hold_par_ff : '0;
         rsp_chd_in   = hold_valid_ff ? hold_chd_ff : '0;
         rsp_empty_in = !hold_valid_ff;
         rsp_last_in  = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff         <= '0;
         cv_ff         <= '0;
         uv_ff         <= '0;
         dmark_ff      <= '0;
         edrop_ff      <= '0;
         e_cnt_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
      end else begin
         pv_ff        <= pv_in;
         cv_ff        <= cv_in;
         uv_ff        <= uv_in;
         dmark_ff     <= dmark_in;
         edrop_ff     <= edrop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.step == STEP_LOAD2) begin
            e_cnt_ff <= e_cnt_ff + CNT_W'(1);
         end else if (cmd.step == STEP_EEND && out_free) begin
            e_cnt_ff <= '0;
         end
         if (cmd.accept) begin
            hold_valid_ff <= 1'b0;
         end else if (cmd.step == STEP_ERD2 && out_free) begin
            hold_valid_ff <= 1'b1;
         end
         if (cmd.step == STEP_DROP2) begin
            chk_valid_ff <= 1'b0;
         end else if (cmd.step == STEP_SCAN) begin
            chk_valid_ff <= 1'b1;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      pq_ff <= pv_ff[p_ra];
      cq_ff <= cv_ff[c_ra];
      uq_ff <= uv_ff[u_ra];
      rsp_par_ff   <= rsp_par_in;
      rsp_chd_ff   <= rsp_chd_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
      if (cmd.accept) begin
         p_ff        <= req_parent_node;
         c_ff        <= req_child_node;
         t_ff        <= req_tip_node;
         i_ff        <= '0;
         drop_cnt_ff <= '0;
         fe_ff       <= '0;
      end
      if (cmd.step == STEP_DROP1) begin
         np_ff <= p_rd;
      end
      if (cmd.step == STEP_DROP2) begin
         scan_ff <= NODE_W'(1);
      end
      // one node entry a cycle, the compare uses the registered read beside its address in chk_k_ff
      if (cmd.step == STEP_SCAN) begin
         scan_ff  <= (scan_ff == LAST_NODE) ? scan_ff : scan_ff + NODE_W'(1);
         chk_k_ff <= scan_ff;
         k_ff     <= chk_k_ff;
      end
      if (cmd.step == STEP_SPL2) begin
         gp_ff <= p_rd;
      end
      if (cmd.step == STEP_NUM) begin
         i_ff <= i_ff + NODE_W'(1);
         if (i_ff != '0 && dmark_ff[i_ff]) begin
            drop_cnt_ff <= drop_cnt_ff + NODE_W'(1);
         end
      end
      if (cmd.step == STEP_ECHK && !status.e_end && status.e_dropped) begin
         fe_ff <= fe_ff + CNT_W'(1);
      end
      if (cmd.step == STEP_ERD2 && out_free) begin
         hold_par_ff <= rn_par;
         hold_chd_ff <= rn_chd;
         fe_ff       <= fe_ff + CNT_W'(1);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_new_parent     = rsp_par_ff;
   assign rsp_new_child_node = rsp_chd_ff;
   assign rsp_is_empty       = rsp_empty_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/tree_tip_pruner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tree tip pruner. Load a rooted tree as parent-child edges (op 0), drop tips
// one per beat (op 1), then finish (op 2) to get the surviving edges in load
// order, renumbered densely, with last set on the final beat, or one beat with
// is_empty set when nothing survives; the store is then cleared. One item is
// worked at a time. A load stores the edge, then counts the child at the
// parent; an ignored load, a tip out of range or an unknown op is taken and
// ignored. A drop clears the tip's parent link and counts the parent down,
// if there is one. When the parent is left with one child, the search for
// that child reads the node parent memory one entry per cycle over slots 1
// to 65, and a hit puts the child in the parent's place. A finish renumbers
// the node slots, then sends each surviving edge and skips each dropped one,
// and closes with the last beat, waiting while the result side stalls.
module tree_tip_pruner (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [1:0]                 req_op,
   input  wire logic [ttp_pkg::NODE_W-1:0] req_parent_node,
   input  wire logic [ttp_pkg::NODE_W-1:0] req_child_node,
   input  wire logic [ttp_pkg::NODE_W-1:0] req_tip_node,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic      [ttp_pkg::NODE_W-1:0] rsp_new_parent,
   output logic      [ttp_pkg::NODE_W-1:0] rsp_new_child_node,
   output logic                            rsp_is_empty,
   output logic                            rsp_last
);
   import ttp_pkg::*;

   ttp_cmd_type    cmd;
   ttp_status_type status;

   // sequencer
   ttp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_op, .req_ready, .status, .cmd
   );

   // stores and result register
   ttp_datapath u_datapath (
      .clock, .reset, .cmd, .status,
      .req_parent_node, .req_child_node, .req_tip_node,
      .rsp_valid, .rsp_ready, .rsp_new_parent, .rsp_new_child_node,
      .rsp_is_empty, .rsp_last
   );

endmodule

`default_nettype wire
